// ===== design/ola_pkg.sv =====
// shared types and constants for the ordered list block
// no dependencies; used by the interfaces, the cell and the top level
package ola_pkg;

   localparam int OP_W  = 2;
   localparam int VAL_W = 32;
   localparam int POS_W = 5;
   localparam int ST_W  = 2;

   typedef enum logic [OP_W-1:0] {
      OP_APPEND   = 2'd0,
      OP_DELETE   = 2'd1,
      OP_TRAVERSE = 2'd2
   } op_type;

   // spare opcode: accepted and dropped with no response
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

   typedef enum logic [ST_W-1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2,
      ST_RANGE = 2'd3
   } status_type;

   // per-cell load select, at most one bit set
   typedef struct packed {
      logic take_new;
      logic take_next;
      logic take_head;
   } cell_sel_type;

endpackage

// ===== design/ola_req_if.sv =====
// request channel: valid/ready handshake with the list command payload
// depends on ola_pkg for field widths
interface ola_req_if;
   logic                              valid;
   logic                              ready;
   logic [ola_pkg::OP_W-1:0]          opcode;
   logic signed [ola_pkg::VAL_W-1:0]  new_value;
   logic [ola_pkg::POS_W-1:0]         target_position;

   modport source (output valid, opcode, new_value, target_position, input ready);
   modport sink   (input valid, opcode, new_value, target_position, output ready);
endinterface

// ===== design/ola_rsp_if.sv =====
// response channel: valid/ready handshake with the result payload
// depends on ola_pkg for field widths
interface ola_rsp_if;
   logic                              valid;
   logic                              ready;
   logic signed [ola_pkg::VAL_W-1:0]  entry_value;
   logic [ola_pkg::ST_W-1:0]          status;
   logic                              last_of_run;

   modport source (output valid, entry_value, status, last_of_run, input ready);
   modport sink   (input valid, entry_value, status, last_of_run, output ready);
endinterface

// ===== design/ola_cell.sv =====
// one storage cell of the list chain: holds one entry, loads from a neighbor
// depends on ola_pkg for the select struct and value width
module ola_cell (
   input  logic                              clock,
   input  ola_pkg::cell_sel_type             sel,
   input  logic signed [ola_pkg::VAL_W-1:0]  next_value,
   input  logic signed [ola_pkg::VAL_W-1:0]  head_value,
   input  logic signed [ola_pkg::VAL_W-1:0]  new_value,
   output logic signed [ola_pkg::VAL_W-1:0]  value
);

   logic signed [ola_pkg::VAL_W-1:0] value_ff;
   logic signed [ola_pkg::VAL_W-1:0] value_in;

   always_comb begin
      priority if (sel.take_new) begin
         value_in = new_value;
      end else if (sel.take_next) begin
         value_in = next_value;
      end else if (sel.take_head) begin
         value_in = head_value;
      end else begin
         value_in = value_ff;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;

endmodule

// ===== design/ordered_list_append_delete.sv =====
// top level of the ordered list: a chain of cells plus count, traverse control
// and the response register; depends on ola_pkg, ola_req_if, ola_rsp_if, ola_cell
//
// Keeps up to DEPTH signed 32-bit entries in list order in a row of cells,
// entry 1 in cell 0. For append and delete the beat is accepted and its single
// response is loaded into the output register at the same edge, and a delete
// moves every later cell one place toward the head at that edge. A traverse is
// accepted and then sends one response per stored entry, or only an empty
// status when the list is empty: the chain rotates by one cell per beat, cell 0
// feeding the response register and wrapping to the tail, so after count beats
// the list is back in order. No request is taken while a traverse is emitting.
// Every beat, also a traverse step, waits for the response register to be free
// or drained in the same cycle, so a stalled sink stalls the block. Full, empty
// and out-of-range requests return a status and leave the list unchanged;
// opcode three is accepted and dropped with no response.
module ordered_list_append_delete #(
   parameter int DEPTH = 16
) (
   input  logic       clock,
   input  logic       reset,
   ola_req_if.sink    req_chan,
   ola_rsp_if.source  rsp_chan
);

   // count width holds 0..DEPTH; compare width also covers the position field
   localparam int CW   = $clog2(DEPTH + 1);
   localparam int CMPW = (CW > ola_pkg::POS_W) ? CW : ola_pkg::POS_W;

   // list state
   logic [CW-1:0] count_ff, count_in;

   // traverse control
   logic          trav_busy_ff, trav_busy_in;
   logic [CW-1:0] trav_left_ff, trav_left_in;

   // response register
   logic                              rsp_valid_ff, rsp_valid_in;
   logic signed [ola_pkg::VAL_W-1:0]  rsp_value_ff, rsp_value_in;
   ola_pkg::status_type               rsp_status_ff, rsp_status_in;
   logic                              rsp_last_ff, rsp_last_in;

   // handshake and decode
   logic            can_load;
   logic            req_fire;
   logic            trav_step;
   logic            is_append, is_delete;
   logic            list_full, list_empty;
   logic [CMPW-1:0] pos_ext, cnt_ext;
   logic            pos_bad;
   logic            append_ok, delete_ok;

   // cell row
   logic signed [ola_pkg::VAL_W-1:0] cell_value [DEPTH];
   ola_pkg::cell_sel_type            cell_sel   [DEPTH];

   // output slot is free if empty or being drained this cycle
   assign can_load   = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = !trav_busy_ff && can_load;
   assign req_fire   = req_chan.valid && req_chan.ready;
   assign trav_step  = trav_busy_ff && can_load;

   assign is_append   = req_fire && (req_chan.opcode == ola_pkg::OP_APPEND);
   assign is_delete   = req_fire && (req_chan.opcode == ola_pkg::OP_DELETE);

   assign list_full  = (count_ff == CW'(DEPTH));
   assign list_empty = (count_ff == '0);
   assign pos_ext    = CMPW'(req_chan.target_position);
   assign cnt_ext    = CMPW'(count_ff);
   assign pos_bad    = (pos_ext == '0) || (pos_ext > cnt_ext);
   assign append_ok  = is_append && !list_full;
   assign delete_ok  = is_delete && !list_empty && !pos_bad;

   // per-cell selects and the chain itself
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      localparam logic [CW-1:0] IDX  = CW'(i);
      localparam logic [CW-1:0] IDX1 = CW'(i + 1);

      logic signed [ola_pkg::VAL_W-1:0] next_value;

      always_comb begin
         cell_sel[i].take_new  = append_ok && (count_ff == IDX);
         // delete closes the gap from the removed position up to the tail;
         // traverse rotates every stored cell toward the head
         cell_sel[i].take_next = (IDX1 < count_ff) &&
                                 ((delete_ok && (CMPW'(IDX1) >= pos_ext)) || trav_step);
         // tail of a rotation picks up the old head
         cell_sel[i].take_head = trav_step && (IDX1 == count_ff);
      end

      if (i == DEPTH - 1) begin : g_tail
         assign next_value = cell_value[i];
      end else begin : g_mid
         assign next_value = cell_value[i + 1];
      end

      ola_cell u_cell (
         .clock      (clock),
         .sel        (cell_sel[i]),
         .next_value (next_value),
         .head_value (cell_value[0]),
         .new_value  (req_chan.new_value),
         .value      (cell_value[i])
      );
   end

   // count, traverse and response next state
   always_comb begin
      count_in      = count_ff;
      trav_busy_in  = trav_busy_ff;
      trav_left_in  = trav_left_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      rsp_last_in   = rsp_last_ff;

      if (trav_step) begin
         // one entry per beat from the head of the chain
         rsp_valid_in  = 1'b1;
         rsp_value_in  = cell_value[0];
         rsp_status_in = ola_pkg::ST_OK;
         rsp_last_in   = (trav_left_ff == CW'(1));
         trav_left_in  = trav_left_ff - CW'(1);
         trav_busy_in  = (trav_left_ff != CW'(1));
      end else if (req_fire) begin
         rsp_value_in = '0;
         rsp_last_in  = 1'b1;
         unique case (req_chan.opcode)
            ola_pkg::OP_APPEND: begin
               rsp_valid_in = 1'b1;
               if (list_full) begin
                  rsp_status_in = ola_pkg::ST_FULL;
               end else begin
                  rsp_status_in = ola_pkg::ST_OK;
                  count_in      = count_ff + CW'(1);
               end
            end
            ola_pkg::OP_DELETE: begin
               rsp_valid_in = 1'b1;
               if (list_empty) begin
                  rsp_status_in = ola_pkg::ST_EMPTY;
               end else if (pos_bad) begin
                  rsp_status_in = ola_pkg::ST_RANGE;
               end else begin
                  rsp_status_in = ola_pkg::ST_OK;
                  count_in      = count_ff - CW'(1);
               end
            end
            ola_pkg::OP_TRAVERSE: begin
               if (list_empty) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = ola_pkg::ST_EMPTY;
               end else begin
                  // entries follow on the next beats
                  trav_busy_in = 1'b1;
                  trav_left_in = count_ff;
               end
            end
            default: begin
               // unused opcode: dropped without a response
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         trav_busy_ff <= 1'b0;
         trav_left_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         trav_busy_ff <= trav_busy_in;
         trav_left_ff <= trav_left_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // response payload needs no reset
   always_ff @(posedge clock) begin
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.entry_value = rsp_value_ff;
   assign rsp_chan.status      = rsp_status_ff;
   assign rsp_chan.last_of_run = rsp_last_ff;

   // count never passes the number of cells
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("entry count beyond depth");

   // a running traverse always has entries left and never more than stored
   a_trav_left: assert property (@(posedge clock) disable iff (reset)
      trav_busy_ff |-> (trav_left_ff != '0) && (trav_left_ff <= count_ff))
      else $error("traverse counter out of range");

   // the list does not change size during a traverse
   a_trav_count: assert property (@(posedge clock) disable iff (reset)
      trav_busy_ff && $past(trav_busy_ff) |-> $stable(count_ff))
      else $error("count moved during traverse");

   // final traverse beat ends the run and is flagged last
   a_trav_end: assert property (@(posedge clock) disable iff (reset)
      trav_step && (trav_left_ff == CW'(1)) |=> !trav_busy_ff && rsp_valid_ff && rsp_last_ff)
      else $error("traverse did not end on its last beat");

   // no request is taken while a traverse is emitting
   a_no_req_busy: assert property (@(posedge clock) disable iff (reset)
      trav_busy_ff |-> !req_fire)
      else $error("request accepted during traverse");

endmodule

// ===== sim/ola_checker.sv =====
`timescale 1ns / 1ps
// response checker for the ordered list: watches both channels, predicts and compares
// depends on ola_pkg, ola_req_if and ola_rsp_if
module ola_checker #(
   parameter int DEPTH = 16
) (
   input  logic clock,
   input  logic reset,
   ola_req_if   req_mon,
   ola_rsp_if   rsp_mon,
   output int   fail_count,
   output int   pending,
   output int   checked
);

   typedef struct packed {
      logic signed [ola_pkg::VAL_W-1:0] value;
      ola_pkg::status_type              status;
      logic                             last;
   } list_result_type;

   list_result_type                  awaited_results[$];
   logic signed [ola_pkg::VAL_W-1:0] list_model [DEPTH];
   int                               list_len;

   initial begin
      fail_count = 0;
      pending    = 0;
      checked    = 0;
      list_len   = 0;
   end

   function automatic list_result_type make_result(
         logic signed [ola_pkg::VAL_W-1:0] value,
         ola_pkg::status_type status, logic last);
      list_result_type r;
      r.value  = value;
      r.status = status;
      r.last   = last;
      return r;
   endfunction

   // apply one request to the list copy and queue the responses it causes
   function automatic void predict_list_op(logic [ola_pkg::OP_W-1:0] op,
                                           logic signed [ola_pkg::VAL_W-1:0] value,
                                           logic [ola_pkg::POS_W-1:0] pos);
      int i;
      case (op)
         ola_pkg::OP_APPEND: begin
            if (list_len >= DEPTH) begin
               awaited_results.push_back(make_result('0, ola_pkg::ST_FULL, 1'b1));
            end else begin
               list_model[list_len] = value;
               list_len++;
               awaited_results.push_back(make_result('0, ola_pkg::ST_OK, 1'b1));
            end
         end
         ola_pkg::OP_DELETE: begin
            if (list_len == 0) begin
               awaited_results.push_back(make_result('0, ola_pkg::ST_EMPTY, 1'b1));
            end else if (pos == 0 || int'(pos) > list_len) begin
               awaited_results.push_back(make_result('0, ola_pkg::ST_RANGE, 1'b1));
            end else begin
               for (i = int'(pos) - 1; i < list_len - 1; i++)
                  list_model[i] = list_model[i + 1];
               list_len--;
               awaited_results.push_back(make_result('0, ola_pkg::ST_OK, 1'b1));
            end
         end
         ola_pkg::OP_TRAVERSE: begin
            if (list_len == 0) begin
               awaited_results.push_back(make_result('0, ola_pkg::ST_EMPTY, 1'b1));
            end else begin
               for (i = 0; i < list_len; i++)
                  awaited_results.push_back(make_result(list_model[i], ola_pkg::ST_OK,
                                                        i == list_len - 1));
            end
         end
         default: ;
      endcase
   endfunction

   always @(posedge clock) begin
      list_result_type want;
      if (reset) begin
         list_len = 0;
         awaited_results.delete();
      end else begin
         if (req_mon.valid && req_mon.ready)
            predict_list_op(req_mon.opcode, req_mon.new_value, req_mon.target_position);
         if (rsp_mon.valid && rsp_mon.ready) begin
            checked++;
            if (awaited_results.size() == 0) begin
               $error("unexpected response beat: value %0d status %0d last %0b",
                      rsp_mon.entry_value, rsp_mon.status, rsp_mon.last_of_run);
               fail_count++;
            end else begin
               want = awaited_results.pop_front();
               if (rsp_mon.entry_value !== want.value) begin
                  $error("entry_value: expected %0d, got %0d", want.value,
                         rsp_mon.entry_value);
                  fail_count++;
               end
               if (rsp_mon.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_mon.status);
                  fail_count++;
               end
               if (rsp_mon.last_of_run !== want.last) begin
                  $error("last_of_run: expected %0b, got %0b", want.last,
                         rsp_mon.last_of_run);
                  fail_count++;
               end
            end
         end
      end
      pending = awaited_results.size();
   end

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// top of the ordered list testbench: clock, reset, request and response stimulus, verdict
// depends on ola_pkg, ola_req_if, ola_rsp_if, ordered_list_append_delete and ola_checker
module tb_top;

   localparam int DEPTH       = 16;
   localparam int RAND_ITEMS  = 415;
   localparam int CYCLE_LIMIT = 250000;
   localparam int DRAIN_WAIT  = 2 * DEPTH;

   logic clock;
   logic reset;
   logic quiet;        // no idling on either side while set
   int   cycle_count;
   int   fail_count;
   int   pending;
   int   checked;
   int   n_append, n_delete, n_traverse, n_ignored;

   ola_req_if req_chan ();
   ola_rsp_if rsp_chan ();

   ordered_list_append_delete #(.DEPTH(DEPTH)) uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   ola_checker #(.DEPTH(DEPTH)) list_check (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_chan),
      .rsp_mon    (rsp_chan),
      .fail_count (fail_count),
      .pending    (pending),
      .checked    (checked)
   );

   // 20 ns clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // watchdog: a hung handshake ends the run here
   initial cycle_count = 0;
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAILED: results differ");
         $finish;
      end
   end

   // response side: drop ready about 11 percent of the time, never while quiet
   initial begin
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_chan.ready = quiet || ($urandom_range(99) >= 11);
      end
   end

   // values biased toward the extremes now and then
   function automatic logic signed [ola_pkg::VAL_W-1:0] pick_value();
      case ($urandom_range(15))
         0:       return 32'sh8000_0000;
         1:       return 32'sh7fff_ffff;
         2:       return '0;
         3:       return '1;
         default: return $urandom;
      endcase
   endfunction

   // positions: mostly within 1..DEPTH, sometimes zero or anywhere in the 5-bit field
   function automatic logic [ola_pkg::POS_W-1:0] pick_position();
      int r;
      r = $urandom_range(99);
      if (r < 70) return ola_pkg::POS_W'($urandom_range(1, DEPTH));
      if (r < 80) return ola_pkg::POS_W'(0);
      return ola_pkg::POS_W'($urandom_range(0, 31));
   endfunction

   // one request beat; random gaps first, payload scrambled while valid is low
   task automatic send_req(input logic [ola_pkg::OP_W-1:0] op,
                           input logic signed [ola_pkg::VAL_W-1:0] value,
                           input logic [ola_pkg::POS_W-1:0] pos);
      while (!quiet && $urandom_range(99) < 11) begin
         req_chan.valid           = 1'b0;
         req_chan.opcode          = ola_pkg::OP_W'($urandom);
         req_chan.new_value       = $urandom;
         req_chan.target_position = ola_pkg::POS_W'($urandom);
         @(negedge clock);
      end
      req_chan.valid           = 1'b1;
      req_chan.opcode          = op;
      req_chan.new_value       = value;
      req_chan.target_position = pos;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      case (op)
         ola_pkg::OP_APPEND:   n_append++;
         ola_pkg::OP_DELETE:   n_delete++;
         ola_pkg::OP_TRAVERSE: n_traverse++;
         default:              n_ignored++;
      endcase
      @(negedge clock);
   endtask

   // hold the request side until every queued response has come back
   task automatic wait_drained();
      req_chan.valid = 1'b0;
      while (pending != 0) @(negedge clock);
   endtask

   initial begin
      int  sent;
      int  r;
      int  run_left;
      bit  grow;
      logic [ola_pkg::OP_W-1:0] op;

      reset                    = 1'b1;
      quiet                    = 1'b0;
      req_chan.valid           = 1'b0;
      req_chan.opcode          = '0;
      req_chan.new_value       = '0;
      req_chan.target_position = '0;
      n_append   = 0;
      n_delete   = 0;
      n_traverse = 0;
      n_ignored  = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: empty list cases
      send_req(ola_pkg::OP_TRAVERSE, 32'sd5, 5'd3);
      send_req(ola_pkg::OP_DELETE, '0, 5'd1);
      // fill to the top with the extreme values mixed in
      send_req(ola_pkg::OP_APPEND, 32'sh8000_0000, 5'd0);
      send_req(ola_pkg::OP_APPEND, 32'sh7fff_ffff, 5'd31);
      send_req(ola_pkg::OP_APPEND, '0, 5'd0);
      send_req(ola_pkg::OP_APPEND, '1, 5'd0);
      for (int i = 4; i < DEPTH; i++)
         send_req(ola_pkg::OP_APPEND, $urandom, ola_pkg::POS_W'($urandom));
      // full list: append rejected, traverse emits every entry
      send_req(ola_pkg::OP_APPEND, 32'sd1234, 5'd0);
      send_req(ola_pkg::OP_TRAVERSE, '0, 5'd0);
      // tail delete, head delete, then out-of-range positions
      send_req(ola_pkg::OP_DELETE, '0, ola_pkg::POS_W'(DEPTH));
      send_req(ola_pkg::OP_DELETE, '0, 5'd1);
      send_req(ola_pkg::OP_DELETE, '0, 5'd0);
      send_req(ola_pkg::OP_DELETE, '0, 5'd31);
      // unused opcode is swallowed with no response
      send_req(ola_pkg::OP_UNUSED, 32'sh5a5a_5a5a, 5'd7);

      // random: sweeps that grow the list and drain it, with random content
      sent     = 0;
      grow     = 1'b0;
      run_left = 0;
      while (sent < RAND_ITEMS) begin
         if (run_left == 0) begin
            grow     = ~grow;
            run_left = $urandom_range(10, 30);
         end
         run_left--;
         quiet = (sent >= 250 && sent < 350);
         if (sent == 150)
            wait_drained();
         r = $urandom_range(99);
         if (r < (grow ? 55 : 15))      op = ola_pkg::OP_APPEND;
         else if (r < 75)               op = ola_pkg::OP_DELETE;
         else if (r < 95)               op = ola_pkg::OP_TRAVERSE;
         else                           op = ola_pkg::OP_UNUSED;
         send_req(op, pick_value(), pick_position());
         if (op != ola_pkg::OP_UNUSED)
            sent++;
      end
      quiet = 1'b0;

      // drain and let the block settle
      wait_drained();
      repeat (DRAIN_WAIT) @(posedge clock);

      $display("run covered %0d appends, %0d deletes, %0d traverses, %0d ignored beats",
               n_append, n_delete, n_traverse, n_ignored);
      $display("%0d response beats checked in %0d cycles", checked, cycle_count);
      if (fail_count == 0 && pending == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

// ===== files.f =====
design/ola_pkg.sv
design/ola_req_if.sv
design/ola_rsp_if.sv
design/ola_cell.sv
design/ordered_list_append_delete.sv
sim/ola_checker.sv
sim/tb_top.sv
